/* design/cdg_pkg.sv */
// shared types, codes and defaults for the click-or-drag gesture tracker
package cdg_pkg;

  localparam int unsigned FingersLoDefault  = 1;
  localparam int unsigned FingersHiDefault  = 5;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic signed [15:0] GainReset        = 16'sd1024;
  // a gain of zero selects 4.0 in Q8.8
  localparam logic signed [15:0] GainDefault      = 16'sd1024;
  localparam logic [15:0]        ThresholdReset   = 16'd5;
  localparam logic [3:0]         FingerCountReset = 4'd1;

  localparam int unsigned ProductW = 32;
  localparam int unsigned ScaledW  = ProductW - 8;

  // input commands
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_MOVE    = 2'd2;

  // result events
  localparam logic [1:0] EV_BEGIN = 2'd0;
  localparam logic [1:0] EV_MOVE  = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;
  localparam logic [1:0] EV_CLICK = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_GAIN      = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_FINGERS   = 2'd2;
  localparam logic [1:0] CFG_CLICK_EN  = 2'd3;

  typedef enum logic [2:0] {
    JOB_PRESS_BEGIN,
    JOB_PRESS_QUIET,
    JOB_END,
    JOB_CLICK,
    JOB_ACCUM,
    JOB_FLUSH,
    JOB_MOVE
  } job_kind_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [3:0]         fingers;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] gain;
    logic [15:0]        click_limit;
    logic [3:0]         finger_count;
    logic               click_enabled;
  } cfg_t;

  typedef struct packed {
    job_kind_e          kind;
    logic [3:0]         fingers;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
  } job_t;

endpackage

/* design/cdg_front.sv */
// front end: accepts input transfers, tracks button and movement total, issues jobs
module cdg_front import cdg_pkg::*; #(
  parameter int unsigned FINGERS_LO = FingersLoDefault,
  parameter int unsigned FINGERS_HI = FingersHiDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic        held_q, held_d;
  logic        active_q, active_d;
  logic [31:0] total_q, total_d;

  logic        accept;
  logic        push;
  logic [15:0] abs_x, abs_y;
  logic [16:0] step_size;
  logic [32:0] total_sum;
  logic [31:0] total_new;
  logic        over_thr;
  logic [3:0]  fingers_clamped;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign abs_x     = in_data_i.delta_x[15] ? (~in_data_i.delta_x + 16'd1) : in_data_i.delta_x;
  assign abs_y     = in_data_i.delta_y[15] ? (~in_data_i.delta_y + 16'd1) : in_data_i.delta_y;
  assign step_size = {1'b0, abs_x} + {1'b0, abs_y};
  assign total_sum = {1'b0, total_q} + {16'd0, step_size};
  // saturate the running total
  assign total_new = total_sum[32] ? '1 : total_sum[31:0];
  assign over_thr  = total_new > {16'd0, cfg_i.click_limit};

  always_comb begin
    fingers_clamped = cfg_i.finger_count;
    if (fingers_clamped < 4'(FINGERS_LO)) fingers_clamped = 4'(FINGERS_LO);
    if (fingers_clamped > 4'(FINGERS_HI)) fingers_clamped = 4'(FINGERS_HI);
  end

  always_comb begin
    held_d        = held_q;
    active_d      = active_q;
    total_d       = total_q;
    push          = 1'b0;
    job_o.kind    = JOB_ACCUM;
    job_o.fingers = fingers_clamped;
    job_o.delta_x = in_data_i.delta_x;
    job_o.delta_y = in_data_i.delta_y;
    if (accept) begin
      unique case (in_data_i.command)
        CMD_PRESS: begin
          held_d     = 1'b1;
          total_d    = '0;
          active_d   = !cfg_i.click_enabled;
          push       = 1'b1;
          job_o.kind = cfg_i.click_enabled ? JOB_PRESS_QUIET : JOB_PRESS_BEGIN;
        end
        CMD_RELEASE: begin
          if (active_q) begin
            push       = 1'b1;
            job_o.kind = JOB_END;
          end else if (cfg_i.click_enabled && (total_q <= {16'd0, cfg_i.click_limit})) begin
            push       = 1'b1;
            job_o.kind = JOB_CLICK;
          end
          held_d   = 1'b0;
          active_d = 1'b0;
        end
        CMD_MOVE: begin
          if (held_q) begin
            total_d = total_new;
            push    = 1'b1;
            if (active_q) begin
              job_o.kind = JOB_MOVE;
            end else if (over_thr) begin
              job_o.kind = JOB_FLUSH;
              active_d   = 1'b1;
            end else begin
              job_o.kind = JOB_ACCUM;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= 1'b0;
      active_q <= 1'b0;
      total_q  <= '0;
    end else begin
      held_q   <= held_d;
      active_q <= active_d;
      total_q  <= total_d;
    end
  end

endmodule

/* design/cdg_queue.sv */
// small job queue between front end and back end
module cdg_queue import cdg_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

/* design/cdg_back.sv */
// back end: scales movement, keeps pending sums and drives the result register
module cdg_back import cdg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      empty_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  // scale stage
  logic                      a_valid_q;
  job_kind_e                 a_kind_q;
  logic [3:0]                a_fingers_q;
  logic signed [ScaledW-1:0] a_sx_q, a_sy_q;

  logic signed [15:0]         gain_eff;
  logic signed [ProductW-1:0] prod_x, prod_y, rnd_x, rnd_y;

  // event stage
  logic               phase_q, phase_d;
  logic signed [31:0] pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_data_q, out_data_d;

  logic               out_free, emits, b_fire, b_done, a_load;
  logic signed [31:0] sat_x, sat_y;

  assign gain_eff = (cfg_i.gain == 16'sd0) ? GainDefault : cfg_i.gain;
  assign prod_x   = job_i.delta_x * gain_eff;
  assign prod_y   = job_i.delta_y * gain_eff;
  // round half away from zero, then divide by 256
  assign rnd_x    = prod_x + (prod_x[ProductW-1] ? ProductW'(127) : ProductW'(128));
  assign rnd_y    = prod_y + (prod_y[ProductW-1] ? ProductW'(127) : ProductW'(128));

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [ScaledW-1:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  assign sat_x = sat_add(pend_x_q, a_sx_q);
  assign sat_y = sat_add(pend_y_q, a_sy_q);

  assign out_free = !out_valid_q || out_ready_i;
  assign emits    = (a_kind_q != JOB_PRESS_QUIET) && (a_kind_q != JOB_ACCUM);
  assign b_fire   = a_valid_q && (!emits || out_free);
  assign b_done   = b_fire && ((a_kind_q != JOB_FLUSH) || phase_q);
  assign a_load   = !empty_i && (!a_valid_q || b_done);
  assign pop_o    = a_load;

  always_comb begin
    phase_d     = phase_q;
    pend_x_d    = pend_x_q;
    pend_y_d    = pend_y_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (b_fire) begin
      // jobs without a result leave a waiting result untouched
      if (emits) begin
        out_valid_d          = 1'b1;
        out_data_d.event_res = EV_MOVE;
        out_data_d.fingers   = '0;
        out_data_d.move_x    = '0;
        out_data_d.move_y    = '0;
        out_data_d.last      = 1'b1;
      end
      unique case (a_kind_q)
        JOB_PRESS_BEGIN: begin
          pend_x_d             = '0;
          pend_y_d             = '0;
          out_data_d.event_res = EV_BEGIN;
          out_data_d.fingers   = a_fingers_q;
        end
        JOB_PRESS_QUIET: begin
          pend_x_d = '0;
          pend_y_d = '0;
        end
        JOB_END:   out_data_d.event_res = EV_END;
        JOB_CLICK: out_data_d.event_res = EV_CLICK;
        JOB_ACCUM: begin
          pend_x_d = sat_x;
          pend_y_d = sat_y;
        end
        JOB_FLUSH: begin
          if (!phase_q) begin
            pend_x_d             = sat_x;
            pend_y_d             = sat_y;
            out_data_d.event_res = EV_BEGIN;
            out_data_d.fingers   = a_fingers_q;
            out_data_d.last      = 1'b0;
            phase_d              = 1'b1;
          end else begin
            out_data_d.move_x = pend_x_q;
            out_data_d.move_y = pend_y_q;
            pend_x_d          = '0;
            pend_y_d          = '0;
            phase_d           = 1'b0;
          end
        end
        JOB_MOVE: begin
          out_data_d.move_x = 32'(a_sx_q);
          out_data_d.move_y = 32'(a_sy_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_kind_q    <= job_i.kind;
      a_fingers_q <= job_i.fingers;
      a_sx_q      <= rnd_x[ProductW-1:8];
      a_sy_q      <= rnd_y[ProductW-1:8];
    end
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      phase_q     <= 1'b0;
      pend_x_q    <= '0;
      pend_y_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_q <= 1'b1;
      end else if (b_done) begin
        a_valid_q <= 1'b0;
      end
      phase_q     <= phase_d;
      pend_x_q    <= pend_x_d;
      pend_y_q    <= pend_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* design/click_or_drag_gesture_tracker.sv */
// top level of the click-or-drag gesture tracker: config registers, front, queue, back
//
// input channel (in_valid_i/in_ready_o/in_data_i) takes press, release and move
// commands; output channel (out_valid_o/out_ready_i/out_data_o) returns begin,
// move, end and click results, with last set on the final result of a command.
// configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must do
// so only while idle, which the block does not enforce. a command is taken every cycle
// while the job queue has room. the front end updates the button state and movement
// total in the cycle of the transfer and queues a job; the back end scales it into the
// scale stage and then registers the result in the result register.
// a move that crosses the click threshold gives two results, a begin and then a move,
// and holds the back end until both are registered; every other command gives at
// most one result, so the sustained rate is one command per cycle without a stall.
// a stalled receiver holds the result register; the queue (QUEUE_DEPTH jobs)
// then fills and in_ready_o drops. reset clears the button and gesture state,
// the totals and the queue, and loads the configuration defaults.
module click_or_drag_gesture_tracker import cdg_pkg::*; #(
  parameter int unsigned FINGERS_LO  = FingersLoDefault,
  parameter int unsigned FINGERS_HI  = FingersHiDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  cfg_t cfg_q;
  logic push, full, pop, empty;
  job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain          <= GainReset;
      cfg_q.click_limit   <= ThresholdReset;
      cfg_q.finger_count  <= FingerCountReset;
      cfg_q.click_enabled <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN:      cfg_q.gain          <= cfg_wdata_i;
        CFG_THRESHOLD: cfg_q.click_limit   <= cfg_wdata_i;
        CFG_FINGERS:   cfg_q.finger_count  <= cfg_wdata_i[3:0];
        CFG_CLICK_EN:  cfg_q.click_enabled <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  cdg_front #(
    .FINGERS_LO(FINGERS_LO),
    .FINGERS_HI(FINGERS_HI)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_in)
  );

  cdg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (job_out)
  );

  cdg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .empty_i    (empty),
    .job_i      (job_out),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // only the begin result of a threshold crossing is followed by another result
  a_last_unless_begin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res != EV_BEGIN) |-> out_data_o.last)
    else $error("non-begin result without last");

  // a begin without last is directly followed by the move carrying the pending sums
  a_begin_then_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last
    |=> out_valid_o && (out_data_o.event_res == EV_MOVE))
    else $error("begin transfer not followed by move");

  a_fingers_only_on_begin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res != EV_BEGIN) |-> (out_data_o.fingers == 4'd0))
    else $error("fingers set outside begin");

  a_motion_only_on_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res != EV_MOVE)
    |-> (out_data_o.move_x == 32'sd0) && (out_data_o.move_y == 32'sd0))
    else $error("motion set outside move");
`endif

endmodule
